// ===== design/yuyv_to_argb_converter_assert.svh =====
`ifndef YUYV_TO_ARGB_CONVERTER_ASSERT_SVH
`define YUYV_TO_ARGB_CONVERTER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define Y2A_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("y2a: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define Y2A_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("y2a: next-cycle check failed");

`endif

// ===== design/y2a_pkg.sv =====
`default_nettype none

package y2a_pkg;

    localparam int QShift = 16;
    localparam int ChanW  = 8;
    // Q16 sums stay within +/- 2^25 for all byte inputs.
    localparam int SumW   = 26;

    localparam logic signed [SumW-1:0] COEF_RV = 26'sd92242;
    localparam logic signed [SumW-1:0] COEF_GU = 26'sd22643;
    localparam logic signed [SumW-1:0] COEF_GV = 26'sd46983;
    localparam logic signed [SumW-1:0] COEF_BU = 26'sd116589;

    localparam logic [ChanW-1:0] ALPHA    = 8'hFF;
    localparam logic [ChanW-1:0] CHAN_MAX = 8'hFF;

    typedef struct packed {
        logic [7:0] y_first;
        logic [7:0] u_shared;
        logic [7:0] y_second;
        logic [7:0] v_shared;
    } in_item_t;

    typedef struct packed {
        logic [31:0] pixel_first;
        logic [31:0] pixel_second;
    } out_item_t;

    // Chroma contributions in Q16, shared by both pixels of a pair.
    typedef struct packed {
        logic signed [SumW-1:0] red;
        logic signed [SumW-1:0] green;
        logic signed [SumW-1:0] blue;
    } chroma_terms_t;

    // Byte minus 128, as a signed value: flip the top bit.
    function automatic logic signed [SumW-1:0] chroma_offset(input logic [7:0] c);
        logic signed [7:0] d;
        d = $signed({~c[7], c[6:0]});
        return {{(SumW-8){d[7]}}, d};
    endfunction

    // Non-negative sums truncate by shift; clamp to 0..255.
    function automatic logic [ChanW-1:0] clamp_channel(input logic signed [SumW-1:0] sum);
        logic [ChanW-1:0] ch;
        if (sum[SumW-1])
            ch = '0;
        else if (|sum[SumW-2:QShift+ChanW])
            ch = CHAN_MAX;
        else
            ch = sum[QShift+ChanW-1:QShift];
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== design/y2a_pixel.sv =====
`default_nettype none

module y2a_pixel (
    input  wire logic [7:0]            luma,
    input  wire y2a_pkg::chroma_terms_t terms,
    output logic [31:0]                pixel
);

    logic signed [y2a_pkg::SumW-1:0] base;
    logic signed [y2a_pkg::SumW-1:0] sum_r;
    logic signed [y2a_pkg::SumW-1:0] sum_g;
    logic signed [y2a_pkg::SumW-1:0] sum_b;

    assign base  = $signed({{(y2a_pkg::SumW-8-y2a_pkg::QShift){1'b0}}, luma,
                            {y2a_pkg::QShift{1'b0}}});
    assign sum_r = base + terms.red;
    assign sum_g = base + terms.green;
    assign sum_b = base + terms.blue;

    assign pixel = {y2a_pkg::ALPHA,
                    y2a_pkg::clamp_channel(sum_r),
                    y2a_pkg::clamp_channel(sum_g),
                    y2a_pkg::clamp_channel(sum_b)};

endmodule

`default_nettype wire

// ===== design/yuyv_to_argb_converter.sv =====
// YUYV 4:2:2 to ARGB8888 converter.
// src channel: one YUYV group per item (y_first, u_shared, y_second, v_shared).
// dst channel: one item per group with two ARGB words, alpha 0xFF, then R, G, B.
// Both channels are valid/ready; an item moves when valid and ready are high.
// Each group passes through the input register, then the result register;
// dst_valid rises once the staged group has moved into the result register.
// Throughput: one group per cycle while dst_ready is high.
// The chroma products and the per-channel add/clamp sit between the two
// registers; chroma terms are computed once and shared by both pixels.
// Reset (rst_n low, async) empties both registers; src_ready is high after.
// When dst_ready is low with a result waiting, one more item is still taken
// into the input register; src_ready then drops until the result drains.
// No state survives an item, so stalls only delay, never alter, results.
`default_nettype none
`include "yuyv_to_argb_converter_assert.svh"

module yuyv_to_argb_converter (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               src_valid,
    output logic                    src_ready,
    input  wire y2a_pkg::in_item_t  src_item,
    output logic                    dst_valid,
    input  wire logic               dst_ready,
    output y2a_pkg::out_item_t      dst_item
);

    logic                  stage_valid_reg;
    logic                  stage_valid_next;
    y2a_pkg::in_item_t     stage_item_reg;
    logic                  dst_valid_reg;
    logic                  dst_valid_next;
    y2a_pkg::out_item_t    dst_item_reg;
    y2a_pkg::out_item_t    result;
    y2a_pkg::chroma_terms_t terms;

    logic signed [y2a_pkg::SumW-1:0] du;
    logic signed [y2a_pkg::SumW-1:0] dv;
    logic                  out_free;
    logic                  stage_move;
    logic                  src_take;

    assign out_free   = !dst_valid_reg || dst_ready;
    assign stage_move = stage_valid_reg && out_free;
    assign src_ready  = !stage_valid_reg || out_free;
    assign src_take   = src_valid && src_ready;

    assign du = y2a_pkg::chroma_offset(stage_item_reg.u_shared);
    assign dv = y2a_pkg::chroma_offset(stage_item_reg.v_shared);

    always_comb
    begin
        terms.red   = y2a_pkg::COEF_RV * dv;
        terms.green = -(y2a_pkg::COEF_GU * du) - (y2a_pkg::COEF_GV * dv);
        terms.blue  = y2a_pkg::COEF_BU * du;
    end

    y2a_pixel u_pixel_first (
        .luma  (stage_item_reg.y_first),
        .terms (terms),
        .pixel (result.pixel_first)
    );

    y2a_pixel u_pixel_second (
        .luma  (stage_item_reg.y_second),
        .terms (terms),
        .pixel (result.pixel_second)
    );

    always_comb
    begin
        if (src_take)
            stage_valid_next = 1'b1;
        else if (stage_move)
            stage_valid_next = 1'b0;
        else
            stage_valid_next = stage_valid_reg;

        if (stage_move)
            dst_valid_next = 1'b1;
        else if (dst_ready)
            dst_valid_next = 1'b0;
        else
            dst_valid_next = dst_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            dst_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            dst_valid_reg   <= dst_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_take)
            stage_item_reg <= src_item;
        if (stage_move)
            dst_item_reg <= result;
    end

    assign dst_valid = dst_valid_reg;
    assign dst_item  = dst_item_reg;

    // an accepted item always lands in the input register
    `Y2A_ASSERT_NEXT(a_take_fills_stage, clk, rst_n, src_take, stage_valid_reg)
    // a staged item with room downstream shows up as a result next cycle
    `Y2A_ASSERT_NEXT(a_move_fills_dst, clk, rst_n, stage_move, dst_valid)
    // backpressure on src only when both registers hold items
    `Y2A_ASSERT_NOW(a_stall_only_full, clk, rst_n, !src_ready,
                    stage_valid_reg && dst_valid_reg && !dst_ready)

endmodule

`default_nettype wire
